// ----- sv/adaptive_background_subtract_macros.svh -----
// Assertion macros shared by the background subtraction RTL.
// Depends on nothing; asserting modules name their clock "clock" and reset "reset".
`ifndef ADAPTIVE_BACKGROUND_SUBTRACT_MACROS_SVH
`define ADAPTIVE_BACKGROUND_SUBTRACT_MACROS_SVH
`ifndef SYNTH
`define ABGS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("abgs assertion failed");
`define ABGS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("abgs assertion failed");
`else
`define ABGS_ASSERT(lbl, prop)
`define ABGS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/abgs_pkg.sv -----
// Types, register codes and defaults for the background subtraction block.
// Depends on nothing.
package abgs_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 512;
   localparam int QUEUE_DEPTH        = 4;
   localparam int RESULT_DEPTH       = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_UPDATE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_UP          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_ROWS        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADAPTIVE_ENABLE  = 3'd5;

   localparam logic [7:0]  RESET_UPDATE_THRESHOLD = 8'd50;
   localparam logic [7:0]  RESET_STEP_UP          = 8'd2;
   localparam logic [9:0]  RESET_BAND_ROWS        = 10'd40;
   localparam logic [10:0] RESET_IMAGE_WIDTH      = 11'd640;
   localparam logic [9:0]  RESET_IMAGE_HEIGHT     = 10'd480;
   localparam logic        RESET_ADAPTIVE_ENABLE  = 1'b1;

   typedef struct packed {
      logic [7:0]  update_threshold;
      logic [7:0]  step_up;
      logic [9:0]  band_rows;
      logic [10:0] image_width;
      logic [9:0]  image_height;
      logic        adaptive_enable;
   } csr_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       capture;
      logic       in_band;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [7:0] foreground;
      logic       frame_end;
   } result_type;

endpackage

// ----- sv/abgs_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on nothing.
module abgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/abgs_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
// Depends on nothing.
module abgs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] data_in,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] data_out
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == NW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ----- sv/abgs_front.sv -----
// Front end: accepts pixels, tracks raster position, band and capture state.
// Depends on abgs_pkg and the assertion macro header.
`include "adaptive_background_subtract_macros.svh"

module abgs_front #(
   parameter int MAX_WIDTH  = abgs_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = abgs_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  abgs_pkg::csr_type                       csr,
   input  logic                                    push,
   input  logic                                    full,
   input  logic [7:0]                              pixel,
   input  logic                                    capture_request,
   output logic                                    q_push,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] q_addr,
   output abgs_pkg::item_type                      q_item
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int XW = ((CW > 11) ? CW : 11) + 1;
   localparam int YW = ((RW > 10) ? RW : 10) + 2;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] band_start_ff, band_start_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic          capture_pending_ff, capture_pending_in;
   logic          reference_valid_ff, reference_valid_in;
   logic          capture_frame_ff, capture_frame_in;

   logic          accept, frame_start, col_wrap, row_wrap, in_band;
   logic [XW-1:0] w_eff;
   logic [YW-1:0] h_eff, band_end, band_next;

   assign accept      = push && !full;
   assign frame_start = (col_ff == '0) && (row_ff == '0);

   always_comb begin
      if (csr.image_width == '0) begin
         w_eff = XW'(1);
      end else if (XW'(csr.image_width) > XW'(MAX_WIDTH)) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = XW'(csr.image_width);
      end
      if (csr.image_height == '0) begin
         h_eff = YW'(1);
      end else if (YW'(csr.image_height) > YW'(MAX_HEIGHT)) begin
         h_eff = YW'(MAX_HEIGHT);
      end else begin
         h_eff = YW'(csr.image_height);
      end
   end

   assign col_wrap = (XW'(col_ff) + XW'(1)) >= w_eff;
   assign row_wrap = (YW'(row_ff) + YW'(1)) >= h_eff;

   always_comb begin
      band_next = YW'(band_start_ff) + YW'(csr.band_rows);
      band_end  = (band_next > h_eff) ? h_eff : band_next;
      in_band   = csr.adaptive_enable && (YW'(row_ff) >= YW'(band_start_ff))
                  && (YW'(row_ff) < band_end);
   end

   always_comb begin
      col_in             = col_ff;
      row_in             = row_ff;
      row_base_in        = row_base_ff;
      band_start_in      = band_start_ff;
      capture_pending_in = capture_pending_ff;
      reference_valid_in = reference_valid_ff;
      capture_frame_in   = capture_frame_ff;
      if (accept) begin
         if (frame_start) begin
            capture_frame_in   = !reference_valid_ff || capture_pending_ff;
            reference_valid_in = 1'b1;
            capture_pending_in = 1'b0;
         end
         if (capture_request) begin
            capture_pending_in = 1'b1;
         end
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               row_in        = '0;
               row_base_in   = '0;
               band_start_in = (band_next >= h_eff) ? '0 : band_next[RW-1:0];
            end else begin
               row_in      = row_ff + RW'(1);
               row_base_in = row_base_ff + AW'(MAX_WIDTH);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff             <= '0;
         row_ff             <= '0;
         row_base_ff        <= '0;
         band_start_ff      <= '0;
         capture_pending_ff <= 1'b0;
         reference_valid_ff <= 1'b0;
         capture_frame_ff   <= 1'b0;
      end else begin
         col_ff             <= col_in;
         row_ff             <= row_in;
         row_base_ff        <= row_base_in;
         band_start_ff      <= band_start_in;
         capture_pending_ff <= capture_pending_in;
         reference_valid_ff <= reference_valid_in;
         capture_frame_ff   <= capture_frame_in;
      end
   end

   assign q_push         = accept;
   assign q_addr         = row_base_ff + AW'(col_ff);
   assign q_item.pixel   = pixel;
   assign q_item.capture = frame_start ? (!reference_valid_ff || capture_pending_ff)
                                       : capture_frame_ff;
   assign q_item.in_band = in_band;
   assign q_item.last    = col_wrap && row_wrap;

   `ABGS_ASSERT_NEXT(a_frame_end_restarts, accept && q_item.last,
                     col_ff == '0 && row_ff == '0 && row_base_ff == '0)
   `ABGS_ASSERT(a_band_needs_enable, (accept && q_item.in_band) |-> csr.adaptive_enable)
   `ABGS_ASSERT(a_first_frame_captured,
                (accept && !reference_valid_ff) |-> (frame_start && q_item.capture))

endmodule

// ----- sv/abgs_back.sv -----
// Back end: reference read-modify-write, capture/adapt rule and result forming.
// Depends on abgs_pkg, abgs_ram and the assertion macro header.
`include "adaptive_background_subtract_macros.svh"

module abgs_back #(
   parameter int MAX_WIDTH  = abgs_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = abgs_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  abgs_pkg::csr_type                       csr,
   input  logic                                    q_empty,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] q_addr,
   input  abgs_pkg::item_type                      q_item,
   output logic                                    q_pop,
   input  logic                                    out_full,
   output logic                                    out_push,
   output abgs_pkg::result_type                    out_data
);

   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   logic               b_valid_ff, b_valid_in;
   logic [AW-1:0]      b_addr_ff;
   abgs_pkg::item_type b_item_ff;
   logic               fwd_hit_ff;
   logic [7:0]         fwd_data_ff;

   logic               issue, b_advance;
   logic [7:0]         rd_data, ref_old, ref_base, ref_new;
   logic [8:0]         ref_up;

   assign b_advance = b_valid_ff && !out_full;
   assign issue     = !q_empty && (!b_valid_ff || b_advance);
   assign q_pop     = issue;

   abgs_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_reference (
      .clock   (clock),
      .wr_en   (b_advance),
      .wr_addr (b_addr_ff),
      .wr_data (ref_new),
      .rd_en   (issue),
      .rd_addr (q_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      ref_old = fwd_hit_ff ? fwd_data_ff : rd_data;
      if (b_item_ff.capture) begin
         ref_base = (b_item_ff.pixel > csr.update_threshold)
                    ? b_item_ff.pixel - csr.update_threshold : 8'd0;
      end else begin
         ref_base = ref_old;
      end
      ref_up  = {1'b0, ref_base} + {1'b0, csr.step_up};
      ref_new = ref_base;
      if (b_item_ff.in_band && (b_item_ff.pixel > ref_base)
          && ((b_item_ff.pixel - ref_base) < csr.update_threshold)) begin
         ref_new = (ref_up > {1'b0, b_item_ff.pixel}) ? b_item_ff.pixel : ref_up[7:0];
      end
   end

   assign out_push            = b_advance;
   assign out_data.foreground = (b_item_ff.pixel > ref_new) ? b_item_ff.pixel - ref_new
                                                            : 8'd0;
   assign out_data.frame_end  = b_item_ff.last;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (issue) begin
         b_valid_in = 1'b1;
      end else if (b_advance) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_addr_ff   <= q_addr;
         b_item_ff   <= q_item;
         fwd_hit_ff  <= b_advance && (b_addr_ff == q_addr);
         fwd_data_ff <= ref_new;
      end
   end

   `ABGS_ASSERT_NEXT(a_forward_on_collision, issue && b_advance && b_addr_ff == q_addr,
                     fwd_hit_ff)
   `ABGS_ASSERT_NEXT(a_stall_holds_item, b_valid_ff && !b_advance,
                     b_valid_ff && $stable(b_addr_ff) && $stable(b_item_ff))
   `ABGS_ASSERT(a_issue_frees_stage, (issue && b_valid_ff) |-> b_advance)

endmodule

// ----- sv/adaptive_background_subtract.sv -----
// Adaptive background subtraction over a raster stream of 8-bit grey pixels.
// Sustained rate is one pixel per clock while neither queue is full: every pixel costs
// one read and one write of the reference RAM, on its separate read and write ports,
// and a same-address write issued together with the read is forwarded. A request is
// accepted into a four-entry queue after its raster position, band and capture
// decision are fixed; the back end reads the reference as it pops the request and
// places the result in a two-entry result queue. The reference RAM needs no clearing
// pass: the first frame after reset is captured.
// Depends on abgs_pkg, abgs_fifo, abgs_front and abgs_back.
module adaptive_background_subtract #(
   parameter int MAX_WIDTH  = abgs_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = abgs_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [7:0]                       req_pixel,
   input  logic                             req_capture_request,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [7:0]                       rsp_foreground,
   output logic                             rsp_frame_end,
   input  logic                             csr_write_enable,
   input  logic [abgs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [abgs_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int QW = AW + $bits(abgs_pkg::item_type);

   abgs_pkg::csr_type    csr_ff, csr_in;
   logic                 q_push, q_full, q_pop, q_empty;
   logic [AW-1:0]        fr_addr, bk_addr;
   abgs_pkg::item_type   fr_item, bk_item;
   logic                 out_push, out_full;
   abgs_pkg::result_type out_data, rsp_data;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            abgs_pkg::CSR_UPDATE_THRESHOLD: csr_in.update_threshold = csr_write_data[7:0];
            abgs_pkg::CSR_STEP_UP:          csr_in.step_up          = csr_write_data[7:0];
            abgs_pkg::CSR_BAND_ROWS:        csr_in.band_rows        = csr_write_data[9:0];
            abgs_pkg::CSR_IMAGE_WIDTH:      csr_in.image_width      = csr_write_data[10:0];
            abgs_pkg::CSR_IMAGE_HEIGHT:     csr_in.image_height     = csr_write_data[9:0];
            abgs_pkg::CSR_ADAPTIVE_ENABLE:  csr_in.adaptive_enable  = csr_write_data[0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.update_threshold <= abgs_pkg::RESET_UPDATE_THRESHOLD;
         csr_ff.step_up          <= abgs_pkg::RESET_STEP_UP;
         csr_ff.band_rows        <= abgs_pkg::RESET_BAND_ROWS;
         csr_ff.image_width      <= abgs_pkg::RESET_IMAGE_WIDTH;
         csr_ff.image_height     <= abgs_pkg::RESET_IMAGE_HEIGHT;
         csr_ff.adaptive_enable  <= abgs_pkg::RESET_ADAPTIVE_ENABLE;
      end else begin
         csr_ff <= csr_in;
      end
   end

   abgs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr_ff),
      .push            (req_push),
      .full            (q_full),
      .pixel           (req_pixel),
      .capture_request (req_capture_request),
      .q_push          (q_push),
      .q_addr          (fr_addr),
      .q_item          (fr_item)
   );

   abgs_fifo #(
      .WIDTH (QW),
      .DEPTH (abgs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .full     (q_full),
      .data_in  ({fr_addr, fr_item}),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out ({bk_addr, bk_item})
   );

   abgs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .q_empty  (q_empty),
      .q_addr   (bk_addr),
      .q_item   (bk_item),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_data)
   );

   abgs_fifo #(
      .WIDTH ($bits(abgs_pkg::result_type)),
      .DEPTH (abgs_pkg::RESULT_DEPTH)
   ) u_results (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .full     (out_full),
      .data_in  (out_data),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .data_out (rsp_data)
   );

   assign req_full       = q_full;
   assign rsp_foreground = rsp_data.foreground;
   assign rsp_frame_end  = rsp_data.frame_end;

endmodule

// ----- tb/tb_adaptive_background_subtract.sv -----
// Self-checking testbench for adaptive_background_subtract: a scoreboard class predicts
// the foreground of each pixel request and checks results in order. Depends on abgs_pkg
// and the adaptive_background_subtract RTL.

localparam int FRAME_COLUMNS = abgs_pkg::MAX_WIDTH_DEFAULT;
localparam int FRAME_ROWS    = abgs_pkg::MAX_HEIGHT_DEFAULT;

class background_scoreboard;
   bit [7:0]  background [0:FRAME_COLUMNS*FRAME_ROWS-1];
   int        row_written [0:FRAME_ROWS-1];
   int        col_pos, row_pos, band_start;
   bit        capture_pending, reference_valid, capture_frame;
   bit [7:0]  threshold, step_up;
   bit [9:0]  band_rows;
   bit [10:0] width_reg;
   bit [9:0]  height_reg;
   bit        adaptive;
   abgs_pkg::result_type expected_foreground [$];
   int        errors;

   function new();
      threshold  = abgs_pkg::RESET_UPDATE_THRESHOLD;
      step_up    = abgs_pkg::RESET_STEP_UP;
      band_rows  = abgs_pkg::RESET_BAND_ROWS;
      width_reg  = abgs_pkg::RESET_IMAGE_WIDTH;
      height_reg = abgs_pkg::RESET_IMAGE_HEIGHT;
      adaptive   = abgs_pkg::RESET_ADAPTIVE_ENABLE;
   endfunction

   function void write_register(logic [abgs_pkg::CSR_INDEX_W-1:0] index,
                                logic [abgs_pkg::CSR_DATA_W-1:0] data);
      case (index)
         abgs_pkg::CSR_UPDATE_THRESHOLD: threshold = data[7:0];
         abgs_pkg::CSR_STEP_UP:          step_up = data[7:0];
         abgs_pkg::CSR_BAND_ROWS:        band_rows = data[9:0];
         abgs_pkg::CSR_IMAGE_WIDTH:      width_reg = data[10:0];
         abgs_pkg::CSR_IMAGE_HEIGHT:     height_reg = data[9:0];
         abgs_pkg::CSR_ADAPTIVE_ENABLE:  adaptive = data[0];
         default: ;
      endcase
   endfunction

   function int clamp_size(int v, int top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function int frame_width();
      return clamp_size(int'(width_reg), FRAME_COLUMNS);
   endfunction

   function int frame_height();
      return clamp_size(int'(height_reg), FRAME_ROWS);
   endfunction

   function bit geometry_safe(logic [10:0] width_raw, logic [10:0] height_raw);
      int w, h;
      w = clamp_size(int'(width_raw), FRAME_COLUMNS);
      h = clamp_size(int'(height_raw[9:0]), FRAME_ROWS);
      if (!reference_valid) return 1;
      if (col_pos == 0 && row_pos == 0 && capture_pending) return 1;
      for (int r = 0; r < h; r++)
         if (row_written[r] < w) return 0;
      return 1;
   endfunction

   function int pixels_to_frame_end();
      int w, h, n;
      w = frame_width();
      h = frame_height();
      n = (col_pos + 1 >= w) ? 1 : w - col_pos;
      if (row_pos + 1 < h) n += (h - 1 - row_pos) * w;
      return n;
   endfunction

   function int next_background();
      return background[row_pos*FRAME_COLUMNS + col_pos];
   endfunction

   function void accept_pixel(logic [7:0] pixel, logic capture_request);
      int w, h, pix, addr, level, band_end;
      abgs_pkg::result_type outcome;
      w = frame_width();
      h = frame_height();
      pix = pixel;
      addr = row_pos*FRAME_COLUMNS + col_pos;
      if (col_pos == 0 && row_pos == 0) begin
         capture_frame = !reference_valid || capture_pending;
         reference_valid = 1;
         capture_pending = 0;
      end
      if (capture_request) capture_pending = 1;
      level = background[addr];
      if (capture_frame) level = (pix > threshold) ? pix - threshold : 0;
      band_end = band_start + band_rows;
      if (band_end > h) band_end = h;
      if (adaptive && row_pos >= band_start && row_pos < band_end
          && pix > level && pix - level < threshold)
         level = (level + step_up > pix) ? pix : level + step_up;
      background[addr] = level[7:0];
      if (row_written[row_pos] < col_pos + 1) row_written[row_pos] = col_pos + 1;
      outcome.foreground = (pix > level) ? 8'(pix - level) : 8'd0;
      outcome.frame_end = 1'b0;
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         if (row_pos + 1 >= h) begin
            row_pos = 0;
            outcome.frame_end = 1'b1;
            band_start += band_rows;
            if (band_start >= h) band_start = 0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
      expected_foreground.push_back(outcome);
   endfunction

   function void compare_result(logic [7:0] foreground, logic frame_end);
      abgs_pkg::result_type want;
      if (expected_foreground.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual foreground %0d frame_end %0d",
                  $time, foreground, frame_end);
         errors++;
         return;
      end
      want = expected_foreground.pop_front();
      if (want.foreground !== foreground) begin
         $display("%0t: foreground expected %0d actual %0d", $time, want.foreground, foreground);
         errors++;
      end
      if (want.frame_end !== frame_end) begin
         $display("%0t: frame_end expected %0d actual %0d", $time, want.frame_end, frame_end);
         errors++;
      end
   endfunction
endclass

module tb_adaptive_background_subtract;

   localparam int PERIOD = 10;
   localparam int RANDOM_PIXELS = 800;

   typedef logic [abgs_pkg::CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [abgs_pkg::CSR_DATA_W-1:0]  csr_data_type;

   logic          clock;
   logic          reset;
   logic          req_push;
   logic          req_full;
   logic [7:0]    req_pixel;
   logic          req_capture_request;
   logic          rsp_empty;
   logic          rsp_pop;
   logic [7:0]    rsp_foreground;
   logic          rsp_frame_end;
   logic          csr_write_enable;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;

   background_scoreboard sb = new();
   bit steady;
   bit hold_results;

   adaptive_background_subtract DUT (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_pixel           (req_pixel),
      .req_capture_request (req_capture_request),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_foreground      (rsp_foreground),
      .rsp_frame_end       (rsp_frame_end),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD/2) clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int hold;
      hold = 0;
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_results && hold == 0) hold = 80;
         if (hold > 0) begin
            rsp_pop <= 1'b0;
            hold--;
            if (hold == 0) hold_results = 0;
         end else begin
            rsp_pop <= steady || ($urandom_range(0, 99) >= 31);
         end
         @(posedge clock);
         if (rsp_pop && !rsp_empty) sb.compare_result(rsp_foreground, rsp_frame_end);
      end
   end

   function automatic logic [7:0] random_pixel();
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 255;
         2, 3, 4: v = $urandom_range(0, 255);
         default: v = sb.next_background() + int'($urandom_range(0, sb.threshold + 1)) - 1;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic logic [7:0] near_background(int delta);
      int v;
      v = sb.next_background() + delta;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic csr_data_type pick_setting(int typical, int top);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return top[abgs_pkg::CSR_DATA_W-1:0];
         2: return csr_data_type'($urandom_range(0, 2047));
         default: return csr_data_type'($urandom_range(0, typical));
      endcase
   endfunction

   task automatic send_pixel(input logic [7:0] pixel, input logic capture_request);
      while (!steady && $urandom_range(0, 99) < 31) begin
         @(negedge clock);
         req_push <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_pixel <= pixel;
      req_capture_request <= capture_request;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.accept_pixel(pixel, capture_request);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.expected_foreground.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input csr_data_type data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      sb.write_register(index, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // grow only into rows already written, or behind a capture request
   task automatic set_geometry(input logic [10:0] width_raw, input logic [10:0] height_raw);
      int remaining;
      if (!sb.geometry_safe(width_raw, height_raw)) begin
         remaining = sb.pixels_to_frame_end();
         for (int i = remaining; i > 0; i--) send_pixel(random_pixel(), i == 1);
         drain_results();
      end
      write_register(abgs_pkg::CSR_IMAGE_WIDTH, width_raw);
      write_register(abgs_pkg::CSR_IMAGE_HEIGHT, height_raw);
   endtask

   task automatic random_settings();
      csr_data_type data;
      logic [10:0] width_raw, height_raw;
      if ($urandom_range(0, 1))
         write_register(abgs_pkg::CSR_UPDATE_THRESHOLD, pick_setting(80, 255));
      if ($urandom_range(0, 1)) write_register(abgs_pkg::CSR_STEP_UP, pick_setting(8, 255));
      if ($urandom_range(0, 1))
         write_register(abgs_pkg::CSR_BAND_ROWS,
                        $urandom_range(0, 3) == 0 ? 11'd512 : pick_setting(6, 1023));
      if ($urandom_range(0, 2) == 0) begin
         data = csr_data_type'($urandom_range(0, 2047));
         data[0] = ($urandom_range(0, 3) != 0);
         write_register(abgs_pkg::CSR_ADAPTIVE_ENABLE, data);
      end
      if ($urandom_range(0, 1)) begin
         width_raw = 11'($urandom_range(0, 24));
         height_raw = 11'($urandom_range(0, 8));
         if ($urandom_range(0, 4) == 0) height_raw[10] = 1'b1;
         set_geometry(width_raw, height_raw);
      end
   endtask

   task automatic directed_frames();
      logic [7:0] first_frame [8] = '{0, 255, 49, 50, 51, 200, 128, 1};
      logic [7:0] second_frame [8] = '{255, 0, 10, 60, 240, 51, 49, 128};
      int offsets [8] = '{1, 49, 50, 0, -1, 2, 300, -300};
      write_register(abgs_pkg::CSR_UPDATE_THRESHOLD, 11'd50);
      write_register(abgs_pkg::CSR_STEP_UP, 11'd2);
      write_register(abgs_pkg::CSR_BAND_ROWS, 11'd1);
      write_register(abgs_pkg::CSR_ADAPTIVE_ENABLE, 11'd1);
      set_geometry(11'd4, 11'd2);
      for (int i = 0; i < 8; i++) send_pixel(first_frame[i], i == 0);
      for (int i = 0; i < 8; i++) send_pixel(second_frame[i], 1'b0);
      for (int i = 0; i < 8; i++) send_pixel(near_background(offsets[i]), 1'b0);
      drain_results();
   endtask

   initial begin
      int count, regular, phase;
      reset = 1'b1;
      req_push = 1'b0;
      req_pixel = '0;
      req_capture_request = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      steady = 0;
      hold_results = 0;
      regular = 0;
      phase = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_frames();

      while (phase < 14 || regular < RANDOM_PIXELS) begin
         drain_results();
         random_settings();
         count = $urandom_range(1, 60);
         case (phase)
            3: begin
               steady = 1;
               count = 150;
            end
            6: begin
               steady = 1;
               hold_results = 1;
               count = 60;
            end
            9: begin
               set_geometry(11'd2047, 11'd0);
               count = FRAME_COLUMNS + 5;
            end
            12: begin
               set_geometry(11'd1, 11'd1023);
               count = FRAME_ROWS + 5;
            end
            default: ;
         endcase
         regular += count;
         for (int i = 0; i < count; i++) send_pixel(random_pixel(), $urandom_range(0, 29) == 0);
         steady = 0;
         phase++;
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_foreground.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
